/* src/pulse_width_bit_decoder_page_store_core_assert.svh */
// assertion macros used by the decoder rtl
`ifndef PULSE_WIDTH_BIT_DECODER_PAGE_STORE_CORE_ASSERT_SVH
`define PULSE_WIDTH_BIT_DECODER_PAGE_STORE_CORE_ASSERT_SVH

// same-cycle implication
`define PWBD_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("pwbd assertion failed");

// next-cycle implication
`define PWBD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("pwbd assertion failed");

`endif

/* src/pwbd_pkg.sv */
// ----------------------------------------------------------------------------
// pwbd_pkg
// types and constants of the pulse width bit decoder with page store
// ----------------------------------------------------------------------------
package pwbd_pkg;

   localparam int PAGE_COUNT_DEF = 8;
   localparam int WORD_BITS      = 32;
   localparam int MODE_PAGE      = 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int PULSE_BITS     = 16;
   localparam int CNT_BITS       = 6;
   localparam int PAGE_OUT_BITS  = 3;
   localparam int MODE_BITS      = 8;

   localparam logic [PULSE_BITS-1:0] WAKE_MIN_RESET = 16'd100;
   localparam logic [PULSE_BITS-1:0] HALF_MIN_RESET = 16'd205;
   localparam logic [PULSE_BITS-1:0] HALF_MAX_RESET = 16'd307;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_WAKE_MIN = 2'd0,
      REG_HALF_MIN = 2'd1,
      REG_HALF_MAX = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_ARMED   = 2'd1,
      PHASE_COLLECT = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_INCOMPLETE = 2'd0,
      STATUS_STORED     = 2'd1,
      STATUS_ERROR      = 2'd2
   } status_type;

   typedef struct packed {
      logic [PULSE_BITS-1:0] wake_min;
      logic [PULSE_BITS-1:0] half_min;
      logic [PULSE_BITS-1:0] half_max;
   } timing_type;

   typedef struct packed {
      status_type             status;
      logic [WORD_BITS-1:0]   word;
   } entry_type;

endpackage

/* src/pwbd_front.sv */
// ----------------------------------------------------------------------------
// pwbd_front
// classifies each pulse, shifts in bits and hands one entry per beat onward
// ----------------------------------------------------------------------------
module pwbd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  pwbd_pkg::timing_type              timing,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_line_level,
   input  logic [pwbd_pkg::PULSE_BITS-1:0]   req_pulse_us,
   output logic                              push_valid,
   input  logic                              push_ready,
   output pwbd_pkg::entry_type               push_data
);
   import pwbd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [WORD_BITS-1:0]  shift_ff, shift_in;
   logic                  accept;
   logic [CNT_BITS-1:0]   count_base;
   logic [WORD_BITS-1:0]  shift_base;
   logic [CNT_BITS-1:0]   count_next;
   logic [WORD_BITS-1:0]  shift_next;
   logic                  in_window;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid & push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         count_ff <= '0;
         shift_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      in_window  = (req_pulse_us >= timing.half_min) && (req_pulse_us <= timing.half_max);
      count_base = (phase_ff == PHASE_ARMED) ? '0 : count_ff;
      shift_base = (phase_ff == PHASE_ARMED) ? '0 : shift_ff;
      count_next = count_base + CNT_BITS'(1);
      shift_next = {req_line_level, shift_base[WORD_BITS-1:1]};
      phase_in   = phase_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      push_data.status = STATUS_INCOMPLETE;
      push_data.word   = '0;
      unique case (phase_ff) inside
         PHASE_ARMED, PHASE_COLLECT: begin
            if (!in_window) begin
               phase_in = PHASE_IDLE;
               count_in = count_base;
               shift_in = shift_base;
               push_data.status = STATUS_ERROR;
            end else if (count_next == CNT_BITS'(WORD_BITS)) begin
               phase_in = PHASE_IDLE;
               count_in = '0;
               shift_in = '0;
               push_data.status = STATUS_STORED;
               push_data.word   = shift_next;
            end else begin
               phase_in = PHASE_COLLECT;
               count_in = count_next;
               shift_in = shift_next;
            end
         end
         default: begin
            if (req_line_level && (req_pulse_us > timing.wake_min)) begin
               phase_in = PHASE_ARMED;
               count_in = '0;
               shift_in = '0;
            end
         end
      endcase
   end

endmodule

/* src/pwbd_queue.sv */
// ----------------------------------------------------------------------------
// pwbd_queue
// short first-in first-out queue between the front and back parts
// ----------------------------------------------------------------------------
module pwbd_queue #(
   parameter int DEPTH = pwbd_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  pwbd_pkg::entry_type   push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output pwbd_pkg::entry_type   pop_data
);
   import pwbd_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);

   entry_type             slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic                  push;
   logic                  pop;

   assign push_ready = (fill_ff < CNT_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      fill_in = fill_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/pwbd_back.sv */
// ----------------------------------------------------------------------------
// pwbd_back
// allocates pages for finished words, keeps page 0 and the mode byte,
// and drives the registered result beat
// ----------------------------------------------------------------------------
`include "pulse_width_bit_decoder_page_store_core_assert.svh"

module pwbd_back #(
   parameter int PAGE_COUNT = pwbd_pkg::PAGE_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  pwbd_pkg::entry_type                  pop_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [pwbd_pkg::WORD_BITS-1:0]       rsp_stored_word,
   output logic [pwbd_pkg::PAGE_OUT_BITS-1:0]   rsp_stored_page,
   output logic [pwbd_pkg::WORD_BITS-1:0]       rsp_first_page_word,
   output logic [pwbd_pkg::MODE_BITS-1:0]       rsp_mode_byte
);
   import pwbd_pkg::*;

   localparam int PIW = $clog2(PAGE_COUNT);

   logic [PAGE_COUNT-1:0]    valid_ff, valid_in;
   logic [WORD_BITS-1:0]     page0_ff, page0_in;
   logic [MODE_BITS-1:0]     mode_ff, mode_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               status_ff, status_in;
   logic [WORD_BITS-1:0]     word_ff, word_in;
   logic [PAGE_OUT_BITS-1:0] page_ff, page_in;
   logic [WORD_BITS-1:0]     first_ff;
   logic [MODE_BITS-1:0]     mode_out_ff;
   logic [PIW-1:0]           free_idx;
   logic                     pop;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      free_idx = '0;
      for (int i = PAGE_COUNT - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = PIW'(i);
         end
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      page0_in     = page0_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = pop_data.status;
      word_in      = '0;
      page_in      = '0;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (pop_data.status == STATUS_STORED) begin
            valid_in[free_idx] = 1'b1;
            if (free_idx == '0) begin
               page0_in = pop_data.word;
            end
            if (free_idx == PIW'(MODE_PAGE)) begin
               mode_in = pop_data.word[WORD_BITS-1 -: MODE_BITS];
            end
            word_in = pop_data.word;
            page_in = PAGE_OUT_BITS'(free_idx);
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         page0_ff     <= '0;
         mode_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         page0_ff     <= page0_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff   <= status_in;
         word_ff     <= word_in;
         page_ff     <= page_in;
         first_ff    <= page0_in;
         mode_out_ff <= mode_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_stored_word     = word_ff;
   assign rsp_stored_page     = page_ff;
   assign rsp_first_page_word = first_ff;
   assign rsp_mode_byte       = mode_out_ff;

   `PWBD_ASSERT_NEXT(a_store_marks_one, clock, reset,
      pop && (pop_data.status == STATUS_STORED) && !(&valid_ff),
      $countones(valid_ff) == $countones($past(valid_ff)) + 1)
   `PWBD_ASSERT_NEXT(a_no_store_keeps_marks, clock, reset,
      !(pop && (pop_data.status == STATUS_STORED)), valid_ff == $past(valid_ff))
   `PWBD_ASSERT_IMPLY(a_page0_clear_until_marked, clock, reset,
      !valid_ff[0], page0_ff == '0)
   `PWBD_ASSERT_IMPLY(a_mode_clear_until_marked, clock, reset,
      !valid_ff[MODE_PAGE], mode_ff == '0)

endmodule

/* src/pulse_width_bit_decoder_page_store_core.sv */
// ----------------------------------------------------------------------------
// pulse_width_bit_decoder_page_store_core
// decodes measured pulse widths into 32-bit words and keeps them in pages
// ----------------------------------------------------------------------------
// req_ beats carry one measured pulse (line level, length in microseconds).
// every req_ beat yields exactly one rsp_ beat: status, the word just stored
// with its page, the current page 0 word and the mode byte.
// csr_ is an apb write/read port for the wake threshold and the bit window;
// write it only while no beat is in flight.
// a taken request beat passes through the queue and then the response register.
// throughput: one beat per cycle while rsp_ready stays high, set by the front
// decoder and the single page allocation step in the back part.
// a two-entry queue between front and back and the response register let
// requests keep flowing while a response waits; once the queue and the
// response register are full, req_ready drops until rsp_ready returns.
// reset returns the decoder to idle, clears all page marks, page 0 and the
// mode byte, and loads the default timing values.
// ----------------------------------------------------------------------------
module pulse_width_bit_decoder_page_store_core #(
   parameter int PAGE_COUNT = pwbd_pkg::PAGE_COUNT_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_line_level,
   input  logic [pwbd_pkg::PULSE_BITS-1:0]         req_pulse_us,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [1:0]                              rsp_status,
   output logic [pwbd_pkg::WORD_BITS-1:0]          rsp_stored_word,
   output logic [pwbd_pkg::PAGE_OUT_BITS-1:0]      rsp_stored_page,
   output logic [pwbd_pkg::WORD_BITS-1:0]          rsp_first_page_word,
   output logic [pwbd_pkg::MODE_BITS-1:0]          rsp_mode_byte,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [pwbd_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [pwbd_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [pwbd_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                    csr_pready
);
   import pwbd_pkg::*;

   timing_type   timing_ff, timing_in;
   logic [1:0]   reg_idx;
   logic         csr_write;
   logic         push_valid, push_ready;
   entry_type    push_data;
   logic         pop_valid, pop_ready;
   entry_type    pop_data;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      timing_in = timing_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_WAKE_MIN: timing_in.wake_min = csr_pwdata[PULSE_BITS-1:0];
            REG_HALF_MIN: timing_in.half_min = csr_pwdata[PULSE_BITS-1:0];
            REG_HALF_MAX: timing_in.half_max = csr_pwdata[PULSE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WAKE_MIN: csr_prdata = CSR_DATA_BITS'(timing_ff.wake_min);
         REG_HALF_MIN: csr_prdata = CSR_DATA_BITS'(timing_ff.half_min);
         REG_HALF_MAX: csr_prdata = CSR_DATA_BITS'(timing_ff.half_max);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.wake_min <= WAKE_MIN_RESET;
         timing_ff.half_min <= HALF_MIN_RESET;
         timing_ff.half_max <= HALF_MAX_RESET;
      end else begin
         timing_ff <= timing_in;
      end
   end

   pwbd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .timing         (timing_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_line_level (req_line_level),
      .req_pulse_us   (req_pulse_us),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   pwbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pwbd_back #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_data            (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_stored_word     (rsp_stored_word),
      .rsp_stored_page     (rsp_stored_page),
      .rsp_first_page_word (rsp_first_page_word),
      .rsp_mode_byte       (rsp_mode_byte)
   );

endmodule
